// ===== rtl/core/sfr_pkg.sv =====
// Shared types and constants for the STX frame receiver.
package sfr_pkg;

  localparam logic [7:0] STX_BYTE = 8'h02;

  typedef enum logic [1:0] {
    KIND_CMD = 2'd0,
    KIND_ANS = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADSUM  = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
  } item_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== rtl/core/sfr_if.sv =====
// Stream interfaces for received bytes and frame results.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output kind, output status, output last,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input status, input last,
                output ready);
endinterface

// ===== rtl/core/sfr_in_stage.sv =====
// Input register for received byte transactions.
module sfr_in_stage
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sfr_in_if.sink     rx,
  input  logic       take,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic vld;

  assign rx.ready  = !vld || take;
  assign ctl.valid = vld;
  assign ctl.take  = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rx.ready) begin
      vld <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      item.rx_byte   <= rx.rx_byte;
      item.timed_out <= rx.timed_out;
    end
  end

endmodule

// ===== rtl/core/sfr_core.sv =====
// Frame state update and result register.
module sfr_core
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  item_t      item,
  output logic       take,
  sfr_out_if.source  tx
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_xor, running_xor_next;

  logic       emit;
  logic [7:0] res_byte;
  kind_t      res_kind;
  status_t    res_status;
  logic       res_last;
  logic       step;

  assign take = !tx.valid || tx.ready;
  assign step = ctl.valid && ctl.take;

  always_comb begin
    phase_next        = phase;
    remaining_next    = remaining;
    frame_length_next = frame_length;
    running_xor_next  = running_xor;
    emit       = 1'b0;
    res_byte   = 8'd0;
    res_kind   = KIND_END;
    res_status = ST_OK;
    res_last   = 1'b0;
    if (item.timed_out) begin
      if (phase != PH_HUNT) begin
        phase_next        = PH_HUNT;
        remaining_next    = 8'd0;
        frame_length_next = 8'd0;
        running_xor_next  = 8'd0;
        emit       = 1'b1;
        res_status = ST_TIMEOUT;
        res_last   = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (item.rx_byte == STX_BYTE) phase_next = PH_LEN;
        end
        PH_LEN: begin
          frame_length_next = item.rx_byte;
          remaining_next    = item.rx_byte;
          running_xor_next  = item.rx_byte;
          phase_next        = (item.rx_byte == 8'd0) ? PH_CHECK : PH_BODY;
        end
        PH_BODY: begin
          running_xor_next = running_xor ^ item.rx_byte;
          remaining_next   = remaining - 8'd1;
          if (remaining == 8'd1) phase_next = PH_CHECK;
          emit     = 1'b1;
          res_byte = item.rx_byte;
          res_kind = (remaining == frame_length) ? KIND_CMD : KIND_ANS;
        end
        PH_CHECK: begin
          phase_next        = PH_HUNT;
          remaining_next    = 8'd0;
          frame_length_next = 8'd0;
          running_xor_next  = 8'd0;
          emit       = 1'b1;
          res_status = (item.rx_byte == running_xor) ? ST_OK : ST_BADSUM;
          res_last   = 1'b1;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      remaining    <= 8'd0;
      frame_length <= 8'd0;
      running_xor  <= 8'd0;
      tx.valid     <= 1'b0;
    end else begin
      if (step) begin
        phase        <= phase_next;
        remaining    <= remaining_next;
        frame_length <= frame_length_next;
        running_xor  <= running_xor_next;
      end
      if (take) tx.valid <= step && emit;
    end
    if (take && step && emit) begin
      tx.out_byte <= res_byte;
      tx.kind     <= res_kind;
      tx.status   <= res_status;
      tx.last     <= res_last;
    end
  end

endmodule

// ===== rtl/core/stx_frame_receiver_unit.sv =====
// Top level of the STX frame receiver.
//
//   channel  dir  payload                          role
//   rx       in   rx_byte, timed_out               received byte or timeout
//   tx       out  out_byte, kind, status, last     body byte or end-of-frame result
//
// One transaction per cycle sustained while tx is not stalled. An accepted byte is
// held in the input register and then decoded into the result register.
// Bytes that give no result are consumed silently. rst is synchronous and returns the
// frame state to hunting. A stalled tx holds its result; rx fills the single input
// register and then stalls until tx is taken.
module stx_frame_receiver_unit
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    rx,
  sfr_out_if.source tx
);

  stage_ctl_t ctl;
  item_t      item;
  logic       take;

  sfr_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .ctl  (ctl),
    .item (item)
  );

  sfr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .item (item),
    .take (take),
    .tx   (tx)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind == KIND_END) |-> (tx.last && tx.out_byte == 8'd0))
    else $error("end result without last or with data");

  a_body_ok: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.kind != KIND_END) |-> (!tx.last && tx.status == ST_OK))
    else $error("body result with status or last");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> (tx.kind != 2'd3 && tx.status != 2'd3))
    else $error("illegal kind or status code");

  a_cmd_then_not_end_status: assert property (@(posedge clk) disable iff (rst)
    (tx.valid && tx.ready && tx.kind == KIND_END) |=> !(tx.valid && tx.kind == KIND_ANS))
    else $error("answer byte directly after end of frame");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the STX frame receiver: directed frames, faults and random traffic.
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned HOLD_OFF       = 300;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LEN,
    PH_BODY,
    PH_CHECK
  } hunt_phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_BADSUM,
    FAULT_TIMEOUT
  } frame_fault_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    status_t    status;
    logic       last;
  } frame_result_t;

  logic clk;
  logic rst;

  sfr_in_if  rx_if ();
  sfr_out_if tx_if ();

  stx_frame_receiver_unit dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  hunt_phase_t     rx_phase;
  logic [7:0]      bytes_left;
  logic [7:0]      body_length;
  logic [7:0]      lrc_acc;
  frame_result_t   expected_results[$];
  int unsigned     error_count;
  int unsigned     items_sent;
  int unsigned     quiet_cycles;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;
  int unsigned     hold_request;
  int unsigned     hold_left;

  always #10 clk = ~clk;

  function automatic void clear_frame_state();
    rx_phase    = PH_HUNT;
    bytes_left  = 8'h00;
    body_length = 8'h00;
    lrc_acc     = 8'h00;
  endfunction

  function automatic bit predict_result(input item_t it, output frame_result_t r);
    bit has;
    has = 1'b0;
    r = '{out_byte: 8'h00, kind: KIND_END, status: ST_OK, last: 1'b1};
    if (it.timed_out) begin
      if (rx_phase != PH_HUNT) begin
        r.status = ST_TIMEOUT;
        has = 1'b1;
        clear_frame_state();
      end
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (it.rx_byte == STX_BYTE) rx_phase = PH_LEN;
        end
        PH_LEN: begin
          body_length = it.rx_byte;
          bytes_left  = it.rx_byte;
          lrc_acc     = it.rx_byte;
          rx_phase    = (it.rx_byte == 8'h00) ? PH_CHECK : PH_BODY;
        end
        PH_BODY: begin
          r.out_byte = it.rx_byte;
          r.kind     = (bytes_left == body_length) ? KIND_CMD : KIND_ANS;
          r.last     = 1'b0;
          lrc_acc    = lrc_acc ^ it.rx_byte;
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'h00) rx_phase = PH_CHECK;
          has = 1'b1;
        end
        default: begin
          r.status = (it.rx_byte == lrc_acc) ? ST_OK : ST_BADSUM;
          has = 1'b1;
          clear_frame_state();
        end
      endcase
    end
    return has;
  endfunction

  // Accepted transactions on both channels, result checking and watchdog.
  always @(posedge clk) begin
    frame_result_t exp_r;
    frame_result_t pred;
    if (rst) begin
      clear_frame_state();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (rx_if.valid && rx_if.ready) begin
        quiet_cycles = 0;
        if (predict_result(item_t'{rx_if.rx_byte, rx_if.timed_out}, pred))
          expected_results = {expected_results, pred};
      end
      if (tx_if.valid && tx_if.ready) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_byte %0h kind %0d status %0d last %0d",
                 tx_if.out_byte, tx_if.kind, tx_if.status, tx_if.last);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (tx_if.out_byte !== exp_r.out_byte) begin
            $error("out_byte: expected %0h, got %0h", exp_r.out_byte, tx_if.out_byte);
            error_count++;
          end
          if (tx_if.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, tx_if.kind);
            error_count++;
          end
          if (tx_if.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, tx_if.status);
            error_count++;
          end
          if (tx_if.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, tx_if.last);
            error_count++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stalls plus an optional long hold-off.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic to);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.rx_byte   <= b;
    rx_if.timed_out <= to;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // cut picks where a timeout replaces a byte: 0 length, 1..len body, len+1 check.
  task automatic send_frame(input int unsigned len, input frame_fault_t fault);
    int unsigned cut;
    logic [7:0]  lrc;
    logic [7:0]  b;
    cut = (fault == FAULT_TIMEOUT) ? $urandom_range(len + 1) : len + 2;
    send_item(STX_BYTE, 1'b0);
    if (cut == 0) begin
      send_item(8'($urandom_range(255)), 1'b1);
      return;
    end
    lrc = len[7:0];
    send_item(lrc, 1'b0);
    for (int unsigned i = 1; i <= len; i++) begin
      if (cut == i) begin
        send_item(8'($urandom_range(255)), 1'b1);
        return;
      end
      b = 8'($urandom_range(255));
      lrc = lrc ^ b;
      send_item(b, 1'b0);
    end
    if (cut == len + 1) begin
      send_item(8'($urandom_range(255)), 1'b1);
      return;
    end
    if (fault == FAULT_BADSUM) lrc = lrc ^ 8'($urandom_range(255, 1));
    send_item(lrc, 1'b0);
  endtask

  task automatic test_hunt_noise();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(STX_BYTE, 1'b1);
  endtask

  task automatic test_empty_frames();
    send_item(STX_BYTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(STX_BYTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
  endtask

  task automatic test_stx_in_body();
    send_item(STX_BYTE, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(STX_BYTE, 1'b0);
    send_item(8'hFF, 1'b0);
  endtask

  task automatic test_timeouts();
    send_item(STX_BYTE, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(STX_BYTE, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(STX_BYTE, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h5A, 1'b1);
  endtask

  task automatic test_max_length();
    send_idle_pct = 20;
    stall_pct     = 20;
    send_frame(255, FAULT_NONE);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = HOLD_OFF;
    for (int i = 0; i < 8; i++) send_frame($urandom_range(6), FAULT_NONE);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall,
                                     input int unsigned n);
    int unsigned  stop_at;
    int unsigned  pick;
    int unsigned  len;
    frame_fault_t fault;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    stop_at       = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        len  = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(31);
        pick = $urandom_range(99);
        fault = (pick < 70) ? FAULT_NONE : (pick < 85) ? FAULT_BADSUM : FAULT_TIMEOUT;
        send_frame(len, fault);
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    rx_if.valid     = 1'b0;
    rx_if.rx_byte   = 8'h00;
    rx_if.timed_out = 1'b0;
    tx_if.ready     = 1'b0;
    error_count     = 0;
    items_sent      = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_request    = 0;
    hold_left       = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_hunt_noise();
    test_empty_frames();
    test_stx_in_body();
    test_timeouts();
    test_max_length();
    test_backpressure();
    test_random_traffic(0, 0, 180);
    test_random_traffic(69, 0, 180);
    test_random_traffic(0, 69, 180);
    test_random_traffic(20, 20, 180);

    rx_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== stx_frame_receiver_unit.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_if.sv
rtl/core/sfr_in_stage.sv
rtl/core/sfr_core.sv
rtl/core/stx_frame_receiver_unit.sv
sim/testbench.sv
